FILE: rtl/core/parity_replacement_cache_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the parity replacement cache table
// Concurrent checks clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef PARITY_REPLACEMENT_CACHE_TABLE_ASSERT_SVH
`define PARITY_REPLACEMENT_CACHE_TABLE_ASSERT_SVH
`ifndef SYNTH
`define PRCT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define PRCT_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PRCT_ASSERT(lbl, prop, msg)
`define PRCT_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/core/prct_pkg.sv
// ----------------------------------------------------------------------------
// prct_pkg
// Shared sizes, operation codes and controller commands of the cache table.
// ----------------------------------------------------------------------------
package prct_pkg;

	localparam int CAPACITY = 32;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 32;
	localparam int WORD_W   = 32;
	localparam int OP_W     = 2;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [OP_W-1:0] OP_READ  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_FILL  = 2'd2;

	typedef struct packed {
		logic capture;
		logic commit;
	} ctl_t;

endpackage

FILE: rtl/core/prct_ctrl.sv
// ----------------------------------------------------------------------------
// prct_ctrl
// Request sequencer: captures a request, then commits it once the result
// register is free.
// ----------------------------------------------------------------------------
`include "parity_replacement_cache_table_assert.svh"

module prct_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output prct_pkg::ctl_t ctl
);

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_COMMIT = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;

	assign req_ready   = (state_q == ST_IDLE);
	assign ctl.capture = req_valid && req_ready;
	assign ctl.commit  = (state_q == ST_COMMIT) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid   = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (ctl.capture) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (ctl.commit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`PRCT_ASSERT_NEVER(a_capture_during_commit, ctl.capture && ctl.commit, "capture while busy")
	`PRCT_ASSERT(a_commit_shows_result, ctl.commit |=> rsp_valid_q, "commit lost its result")
	`PRCT_ASSERT(a_result_held, (rsp_valid_q && !rsp_ready) |=> rsp_valid_q, "result dropped")

endmodule

FILE: rtl/core/prct_dp.sv
// ----------------------------------------------------------------------------
// prct_dp
// Entry storage, parallel address compare, oldest-match select, insertion
// with parity-chosen victim, and the result register.
// ----------------------------------------------------------------------------
`include "parity_replacement_cache_table_assert.svh"

module prct_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  prct_pkg::ctl_t                ctl,
	input  logic [prct_pkg::OP_W-1:0]     operation,
	input  logic [prct_pkg::ADDR_W-1:0]   address,
	input  logic [prct_pkg::WORD_W-1:0]   write_data,
	output logic                          hit,
	output logic [prct_pkg::WORD_W-1:0]   read_data,
	output logic                          evicted_valid,
	output logic [prct_pkg::ADDR_W-1:0]   evicted_address,
	output logic [prct_pkg::WORD_W-1:0]   evicted_data,
	output logic                          evicted_clean
);

	localparam int CAP = prct_pkg::CAPACITY;

	// table
	logic [prct_pkg::ADDR_W-1:0] ent_addr_q  [CAP];
	logic [prct_pkg::DATA_W-1:0] ent_data_q  [CAP];
	logic                        ent_clean_q [CAP];
	logic [prct_pkg::CNT_W-1:0]  count_q;

	// captured request
	logic [prct_pkg::OP_W-1:0]   op_s1;
	logic [prct_pkg::ADDR_W-1:0] addr_s1;
	logic [prct_pkg::DATA_W-1:0] wdata_s1;
	logic [CAP-1:0]              match_s1;

	// result register
	logic                        hit_q;
	logic [prct_pkg::WORD_W-1:0] read_data_q;
	logic                        ev_valid_q;
	logic [prct_pkg::ADDR_W-1:0] ev_addr_q;
	logic [prct_pkg::WORD_W-1:0] ev_data_q;
	logic                        ev_clean_q;

	logic [CAP-1:0]              match_now;
	logic [CAP-1:0]              first_oh;
	logic [CAP-1:0]              ins_sel;
	logic [prct_pkg::DATA_W-1:0] hit_data;
	logic                        any_hit;
	logic                        is_read;
	logic                        is_write;
	logic                        is_fill;
	logic                        ins_req;
	logic                        full;
	logic                        ev_shift;
	logic [prct_pkg::ADDR_W-1:0] shift_addr  [CAP];
	logic [prct_pkg::DATA_W-1:0] shift_data  [CAP];
	logic                        shift_clean [CAP];

	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			match_now[i] = (ent_addr_q[i] == address) &&
				(prct_pkg::CNT_W'(i) < count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			op_s1    <= operation;
			addr_s1  <= address;
			wdata_s1 <= prct_pkg::DATA_W'(write_data);
			match_s1 <= match_now;
		end
	end

	assign first_oh = match_s1 & (~match_s1 + CAP'(1));
	assign any_hit  = |match_s1;
	assign is_read  = (op_s1 == prct_pkg::OP_READ);
	assign is_write = (op_s1 == prct_pkg::OP_WRITE);
	assign is_fill  = (op_s1 == prct_pkg::OP_FILL);
	assign ins_req  = (is_write && !any_hit) || is_fill;
	assign full     = (count_q == prct_pkg::CNT_W'(CAP));
	assign ev_shift = ins_req && full && !addr_s1[0];

	always_comb begin
		hit_data = '0;
		for (int i = 0; i < CAP; i++) begin
			if (first_oh[i]) begin
				hit_data = hit_data | ent_data_q[i];
			end
			ins_sel[i] = full ? (i == CAP - 1) : (count_q == prct_pkg::CNT_W'(i));
		end
	end

	for (genvar g = 0; g < CAP; g++) begin : g_entry
		if (g < CAP - 1) begin : g_mid
			assign shift_addr[g]  = ent_addr_q[g + 1];
			assign shift_data[g]  = ent_data_q[g + 1];
			assign shift_clean[g] = ent_clean_q[g + 1];
		end else begin : g_top
			assign shift_addr[g]  = addr_s1;
			assign shift_data[g]  = wdata_s1;
			assign shift_clean[g] = is_fill;
		end

		always_ff @(posedge clk) begin
			if (ctl.commit) begin
				if (ev_shift) begin
					ent_addr_q[g]  <= shift_addr[g];
					ent_data_q[g]  <= shift_data[g];
					ent_clean_q[g] <= shift_clean[g];
				end else if (ins_req && ins_sel[g]) begin
					ent_addr_q[g]  <= addr_s1;
					ent_data_q[g]  <= wdata_s1;
					ent_clean_q[g] <= is_fill;
				end else if (is_write && first_oh[g]) begin
					ent_data_q[g]  <= wdata_s1;
					ent_clean_q[g] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.commit && ins_req && !full) begin
			count_q <= count_q + prct_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			hit_q       <= (is_read || is_write) && any_hit;
			read_data_q <= (is_read && any_hit) ? prct_pkg::WORD_W'(hit_data) : '0;
			ev_valid_q  <= ins_req && full;
			if (ins_req && full) begin
				ev_addr_q  <= addr_s1[0] ? ent_addr_q[CAP - 1] : ent_addr_q[0];
				ev_data_q  <= prct_pkg::WORD_W'(addr_s1[0] ? ent_data_q[CAP - 1]
					: ent_data_q[0]);
				ev_clean_q <= addr_s1[0] ? ent_clean_q[CAP - 1] : ent_clean_q[0];
			end else begin
				ev_addr_q  <= '0;
				ev_data_q  <= '0;
				ev_clean_q <= 1'b0;
			end
		end
	end

	assign hit             = hit_q;
	assign read_data       = read_data_q;
	assign evicted_valid   = ev_valid_q;
	assign evicted_address = ev_addr_q;
	assign evicted_data    = ev_data_q;
	assign evicted_clean   = ev_clean_q;

	`PRCT_ASSERT(a_count_bounded, count_q <= prct_pkg::CNT_W'(CAP), "entry count overflow")
	`PRCT_ASSERT(a_full_stays_full, (ctl.commit && ins_req && full) |=> full, "full table shrank")
	`PRCT_ASSERT(a_fill_no_hit, (ctl.commit && is_fill) |=> !hit_q, "fill reported a hit")

endmodule

FILE: rtl/core/parity_replacement_cache_table.sv
// ----------------------------------------------------------------------------
// parity_replacement_cache_table
// Fully associative address/data table kept in arrival order; a full table
// evicts the oldest entry on an even address and the youngest on an odd one.
//
//   channel  signals                          transfer when
//   req      req_valid/req_ready, operation,  req_valid && req_ready
//            address, write_data
//   rsp      rsp_valid/rsp_ready, hit,        rsp_valid && rsp_ready
//            read_data, evicted_*
//
// A request is handled in a compare step, which checks the address against every
// entry, and a commit step, which picks the oldest match, updates the table and loads the result.
// A new request is taken while the previous result still waits in the
// result register; its commit waits until that result is transferred.
// Reset clears the entry count, the sequencer state and the result valid flag; entry contents need no clearing pass.
// ----------------------------------------------------------------------------
module parity_replacement_cache_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [prct_pkg::OP_W-1:0]   operation,
	input  logic [prct_pkg::ADDR_W-1:0] address,
	input  logic [prct_pkg::WORD_W-1:0] write_data,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic                        hit,
	output logic [prct_pkg::WORD_W-1:0] read_data,
	output logic                        evicted_valid,
	output logic [prct_pkg::ADDR_W-1:0] evicted_address,
	output logic [prct_pkg::WORD_W-1:0] evicted_data,
	output logic                        evicted_clean
);

	prct_pkg::ctl_t ctl;

	prct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.ctl       (ctl)
	);

	prct_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.operation       (operation),
		.address         (address),
		.write_data      (write_data),
		.hit             (hit),
		.read_data       (read_data),
		.evicted_valid   (evicted_valid),
		.evicted_address (evicted_address),
		.evicted_data    (evicted_data),
		.evicted_clean   (evicted_clean)
	);

endmodule
